[design/q2e_pkg.sv]
// Shared types, constants and the arctangent table for the quaternion to Euler unit.
`default_nettype none
package q2e_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  // One isqrt step per result bit: the radicand is at most 2^56.
  localparam int ISQ_STEPS = 29;
  localparam int IW = 58;
  localparam int CW = 38;
  localparam int ZW = 35;
  localparam int AW = 36;

  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [26:0] DEG_PER_RAD_Q20 = 27'sd60078979;
  localparam logic signed [CW-1:0] ONE_Q28 = 38'sd268435456;

  localparam logic CFG_DEGREE_MODE = 1'b0;
  localparam logic CFG_POLE_THRESHOLD = 1'b1;
  localparam logic [13:0] POLE_THRESHOLD_RST = 14'd8176;

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_e;

  // round(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_entry(input int i);
    logic [29:0] v;
    case (i)
      0: v = 30'd843314857;
      1: v = 30'd497837829;
      2: v = 30'd263043837;
      3: v = 30'd133525159;
      4: v = 30'd67021687;
      5: v = 30'd33543516;
      6: v = 30'd16775851;
      7: v = 30'd8388437;
      8: v = 30'd4194283;
      9: v = 30'd2097149;
      default: v = (i < 31) ? (30'd1 << (30 - i)) : 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[design/quaternion_to_euler_unit.sv]
// Top level of the quaternion to Euler angle converter.
// The unit takes one quaternion request per cycle while the output is not stalled and returns
// heading, attitude and bank in signed Q15.16 (radians or degrees) with a pole flag. The
// result passes through the 29-step pipelined square root for the attitude cosine followed
// by the unrolled CORDIC stages. A stall on the output while a result is valid freezes the
// whole pipeline, and the input stall follows it in the same cycle.
`default_nettype none
module quaternion_to_euler_unit #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  logic signed [15:0] quat_x_i,
  input  wire  logic signed [15:0] quat_y_i,
  input  wire  logic signed [15:0] quat_z_i,
  input  wire  logic signed [15:0] quat_w_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic signed [31:0] heading_o,
  output logic signed [31:0] attitude_o,
  output logic signed [31:0] bank_o,
  output logic [1:0]         pole_case_o,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire                cfg_index_i,
  input  wire  logic [13:0]  cfg_data_i
);
  import q2e_pkg::*;

  localparam int ISQ0 = 2;
  localparam int COR_IN = ISQ0 + ISQ_STEPS;
  localparam int COR_OUT = COR_IN + 1 + CORDIC_STAGES;
  localparam int POST = COR_OUT + 1;
  localparam int MUL = POST + 1;
  localparam int DEPTH = MUL + 2;

  logic        degree_mode_q;
  logic [13:0] pole_threshold_q;
  logic        en;
  logic        valid_q [0:DEPTH-1];
  pole_e       pole_q [1:DEPTH-1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_mode_q <= 1'b0;
      pole_threshold_q <= POLE_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEGREE_MODE:    degree_mode_q <= cfg_data_i[0];
        CFG_POLE_THRESHOLD: pole_threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en = !(valid_q[DEPTH-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) valid_q[i] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid_i;
      for (int i = 1; i < DEPTH; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  // Products of components.
  logic signed [31:0] pxy_q, pzw_q, pyw_q, pxz_q, pxw_q, pyz_q, pxx_q, pyy_q, pzz_q;
  logic signed [15:0] qx_q, qw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxy_q <= quat_x_i * quat_y_i;
      pzw_q <= quat_z_i * quat_w_i;
      pyw_q <= quat_y_i * quat_w_i;
      pxz_q <= quat_x_i * quat_z_i;
      pxw_q <= quat_x_i * quat_w_i;
      pyz_q <= quat_y_i * quat_z_i;
      pxx_q <= quat_x_i * quat_x_i;
      pyy_q <= quat_y_i * quat_y_i;
      pzz_q <= quat_z_i * quat_z_i;
      qx_q <= quat_x_i;
      qw_q <= quat_w_i;
    end
  end

  // Sums, pole test, sine clamp and the heading and bank vectors.
  logic signed [33:0] t_b, s2_b, thr_b;
  logic signed [29:0] s_b;
  pole_e              pole_b;
  logic signed [CW-1:0] hy_b, hx_b, by_b, bx_b;

  always_comb begin
    t_b = 34'(pxy_q) + 34'(pzw_q);
    thr_b = signed'({6'b0, pole_threshold_q, 14'b0});
    if (t_b > thr_b) begin
      pole_b = POLE_NORTH;
    end else if (t_b < -thr_b) begin
      pole_b = POLE_SOUTH;
    end else begin
      pole_b = POLE_NONE;
    end
    s2_b = t_b <<< 1;
    if (s2_b > 34'sd268435456) begin
      s_b = 30'sd268435456;
    end else if (s2_b < -34'sd268435456) begin
      s_b = -30'sd268435456;
    end else begin
      s_b = 30'(s2_b);
    end
    if (pole_b != POLE_NONE) begin
      hy_b = CW'(qx_q);
      hx_b = CW'(qw_q);
    end else begin
      hy_b = (CW'(pyw_q) - CW'(pxz_q)) <<< 1;
      hx_b = ONE_Q28 - (CW'(pyy_q) <<< 1) - (CW'(pzz_q) <<< 1);
    end
    by_b = (CW'(pxw_q) - CW'(pyz_q)) <<< 1;
    bx_b = ONE_Q28 - (CW'(pxx_q) <<< 1) - (CW'(pzz_q) <<< 1);
  end

  logic signed [29:0]   s_q;
  logic signed [CW-1:0] hy_q, hx_q, by_q, bx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pole_q[1] <= pole_b;
      for (int i = 2; i < DEPTH; i++) pole_q[i] <= pole_q[i-1];
      s_q <= s_b;
      hy_q <= hy_b;
      hx_q <= hx_b;
      by_q <= by_b;
      bx_q <= bx_b;
    end
  end

  // Cosine radicand and the digit-by-digit square root.
  logic signed [59:0]   sq;
  logic [IW-1:0]        isq_v_q [0:ISQ_STEPS];
  logic [IW-1:0]        isq_r_q [0:ISQ_STEPS];
  logic signed [29:0]   sd_q [0:ISQ_STEPS];
  logic signed [CW-1:0] hyd_q [0:ISQ_STEPS];
  logic signed [CW-1:0] hxd_q [0:ISQ_STEPS];
  logic signed [CW-1:0] byd_q [0:ISQ_STEPS];
  logic signed [CW-1:0] bxd_q [0:ISQ_STEPS];

  assign sq = s_q * s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      isq_v_q[0] <= (IW'(1) << 56) - IW'(sq);
      isq_r_q[0] <= '0;
      sd_q[0] <= s_q;
      hyd_q[0] <= hy_q;
      hxd_q[0] <= hx_q;
      byd_q[0] <= by_q;
      bxd_q[0] <= bx_q;
    end
  end

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
    localparam logic [IW-1:0] BIT = IW'(1) << (56 - 2 * k);
    logic [IW-1:0] trial;
    assign trial = isq_r_q[k] + BIT;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (isq_v_q[k] >= trial) begin
          isq_v_q[k+1] <= isq_v_q[k] - trial;
          isq_r_q[k+1] <= (isq_r_q[k] >> 1) + BIT;
        end else begin
          isq_v_q[k+1] <= isq_v_q[k];
          isq_r_q[k+1] <= isq_r_q[k] >> 1;
        end
        sd_q[k+1] <= sd_q[k];
        hyd_q[k+1] <= hyd_q[k];
        hxd_q[k+1] <= hxd_q[k];
        byd_q[k+1] <= byd_q[k];
        bxd_q[k+1] <= bxd_q[k];
      end
    end
  end

  // Three arctangents in parallel.
  logic signed [ZW-1:0] z_head, z_att, z_bank;

  q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_head (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (hyd_q[ISQ_STEPS]),
    .x_i   (hxd_q[ISQ_STEPS]),
    .z_o   (z_head)
  );

  q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_att (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (CW'(sd_q[ISQ_STEPS])),
    .x_i   (signed'(isq_r_q[ISQ_STEPS][CW-1:0])),
    .z_o   (z_att)
  );

  q2e_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_bank (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (byd_q[ISQ_STEPS]),
    .x_i   (bxd_q[ISQ_STEPS]),
    .z_o   (z_bank)
  );

  // Pole overrides, then the unit conversion split into two partial products.
  logic signed [AW-1:0] ang_q [0:2];
  logic signed [46:0]   phi_q [0:2];
  logic signed [43:0]   plo_q [0:2];
  logic signed [31:0]   rad_q [0:2];
  logic signed [AW-1:0] rsum  [0:2];
  logic signed [63:0]   dsum  [0:2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      case (pole_q[COR_OUT])
        POLE_NORTH: begin
          ang_q[0] <= AW'(z_head) <<< 1;
          ang_q[1] <= HALF_PI_Q30;
          ang_q[2] <= '0;
        end
        POLE_SOUTH: begin
          ang_q[0] <= -(AW'(z_head) <<< 1);
          ang_q[1] <= -HALF_PI_Q30;
          ang_q[2] <= '0;
        end
        default: begin
          ang_q[0] <= AW'(z_head);
          ang_q[1] <= AW'(z_att);
          ang_q[2] <= AW'(z_bank);
        end
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rsum[a] = ang_q[a] + AW'(8192);
      dsum[a] = (64'(phi_q[a]) <<< 16) + 64'(plo_q[a]) + (64'sd1 <<< 33);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        phi_q[a] <= signed'(ang_q[a][AW-1:16]) * DEG_PER_RAD_Q20;
        plo_q[a] <= signed'({1'b0, ang_q[a][15:0]}) * DEG_PER_RAD_Q20;
        rad_q[a] <= 32'(rsum[a] >>> 14);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      heading_o  <= degree_mode_q ? 32'(dsum[0] >>> 34) : rad_q[0];
      attitude_o <= degree_mode_q ? 32'(dsum[1] >>> 34) : rad_q[1];
      bank_o     <= degree_mode_q ? 32'(dsum[2] >>> 34) : rad_q[2];
    end
  end

  assign out_valid_o = valid_q[DEPTH-1];
  assign pole_case_o = pole_q[DEPTH-1];

endmodule
`default_nettype wire

[design/q2e_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(y, x) in Q30 radians.
`default_nettype none
module q2e_cordic #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 en_i,
  input  wire  logic signed [q2e_pkg::CW-1:0] y_i,
  input  wire  logic signed [q2e_pkg::CW-1:0] x_i,
  output logic signed [q2e_pkg::ZW-1:0]       z_o
);
  import q2e_pkg::*;

  logic signed [CW-1:0] x_q [0:CORDIC_STAGES];
  logic signed [CW-1:0] y_q [0:CORDIC_STAGES];
  logic signed [ZW-1:0] z_q [0:CORDIC_STAGES];
  logic                 zero_q [0:CORDIC_STAGES];

  // Left half plane is folded over by a half turn before the iterations.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_entry(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ANG;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ANG;
        end
      end
    end
  end

  assign z_o = zero_q[CORDIC_STAGES] ? '0 : z_q[CORDIC_STAGES];

endmodule
`default_nettype wire

[dv/q2e_scoreboard.sv]
// Checker for the quaternion to Euler unit: predicts every result and compares it.
`timescale 1ns / 100ps
module q2e_scoreboard (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_stall_i,
  input  wire signed [15:0] quat_x_i,
  input  wire signed [15:0] quat_y_i,
  input  wire signed [15:0] quat_z_i,
  input  wire signed [15:0] quat_w_i,
  input  wire               out_valid_i,
  input  wire               out_stall_i,
  input  wire signed [31:0] heading_i,
  input  wire signed [31:0] attitude_i,
  input  wire signed [31:0] bank_i,
  input  wire [1:0]         pole_case_i,
  input  wire               cfg_valid_i,
  input  wire               cfg_ready_i,
  input  wire               cfg_index_i,
  input  wire [13:0]        cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import q2e_pkg::*;

  typedef struct packed {
    logic [31:0] heading;
    logic [31:0] attitude;
    logic [31:0] bank;
    pole_e       pole;
  } euler_t;

  localparam longint ARCTAN_Q30 [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768
  };
  localparam longint PI_ANGLE = 64'sd3373259426;
  localparam longint HALF_PI_ANGLE = 64'sd1686629713;
  localparam longint ONE_UNIT = 64'sd268435456;
  localparam longint RAD_TO_DEG = 64'sd60078979;

  logic        deg_mode;
  logic [13:0] threshold;
  euler_t      angle_q[$];
  int          mismatches;

  function automatic longint vector_angle(longint y, longint x);
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      ang = (y >= 0) ? PI_ANGLE : -PI_ANGLE;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        ang += ARCTAN_Q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        ang -= ARCTAN_Q30[i];
      end
    end
    return ang;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [31:0] scale_angle(longint a);
    longint r;
    if (deg_mode) r = (a * RAD_TO_DEG + (64'sd1 <<< 33)) >>> 34;
    else r = (a + (64'sd1 <<< 13)) >>> 14;
    return r[31:0];
  endfunction

  function automatic euler_t predict_euler(longint x, longint y, longint z, longint w);
    longint t;
    longint thr;
    longint s;
    longint c;
    longint hd;
    longint at;
    longint bk;
    euler_t e;
    t = x * y + z * w;
    thr = longint'(threshold) <<< 14;
    if (t > thr) begin
      hd = 2 * vector_angle(x, w);
      at = HALF_PI_ANGLE;
      bk = 0;
      e.pole = POLE_NORTH;
    end else if (t < -thr) begin
      hd = -2 * vector_angle(x, w);
      at = -HALF_PI_ANGLE;
      bk = 0;
      e.pole = POLE_SOUTH;
    end else begin
      s = 2 * t;
      hd = vector_angle(2 * y * w - 2 * x * z, ONE_UNIT - 2 * y * y - 2 * z * z);
      bk = vector_angle(2 * x * w - 2 * y * z, ONE_UNIT - 2 * x * x - 2 * z * z);
      if (s > ONE_UNIT) s = ONE_UNIT;
      if (s < -ONE_UNIT) s = -ONE_UNIT;
      c = floor_sqrt((64'd1 << 56) - longint'(s * s));
      at = vector_angle(s, c);
      e.pole = POLE_NONE;
    end
    e.heading = scale_angle(hd);
    e.attitude = scale_angle(at);
    e.bank = scale_angle(bk);
    return e;
  endfunction

  assign pending_o = angle_q.size();
  assign fail_count_o = mismatches;

  always @(posedge clk_i or negedge rst_ni) begin
    euler_t want;
    if (!rst_ni) begin
      deg_mode <= 1'b0;
      threshold <= POLE_THRESHOLD_RST;
      mismatches <= 0;
      angle_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_DEGREE_MODE) deg_mode <= cfg_data_i[0];
        else if (cfg_index_i == CFG_POLE_THRESHOLD) threshold <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        angle_q.push_back(predict_euler(quat_x_i, quat_y_i, quat_z_i, quat_w_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (angle_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result at %0t", $realtime);
          mismatches <= mismatches + 1;
        end else begin
          want = angle_q.pop_front();
          if (want.heading !== heading_i || want.attitude !== attitude_i ||
              want.bank !== bank_i || 2'(want.pole) !== pole_case_i) begin
            if (mismatches < 10)
              $display("mismatch: exp %h %h %h %0d, got %h %h %h %0d", want.heading,
                       want.attitude, want.bank, want.pole, heading_i, attitude_i,
                       bank_i, pole_case_i);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

[dv/quaternion_to_euler_unit_tb.sv]
// Stimulus and verdict for the quaternion to Euler unit testbench.
`timescale 1ns / 100ps
module quaternion_to_euler_unit_tb;
  import q2e_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] qx = '0, qy = '0, qz = '0, qw = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] heading, attitude, bank;
  logic [1:0]         pole_case;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_DEGREE_MODE;
  logic [13:0]        cfg_data = '0;
  int                 fail_count, pending;
  int                 phase = 0;
  logic               hold_req = 1'b0;
  logic               hold_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  quaternion_to_euler_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .quat_x_i(qx), .quat_y_i(qy), .quat_z_i(qz), .quat_w_i(qw),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .heading_o(heading), .attitude_o(attitude), .bank_o(bank), .pole_case_o(pole_case),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  q2e_scoreboard checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .quat_x_i(qx), .quat_y_i(qy), .quat_z_i(qz), .quat_w_i(qw),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .heading_i(heading), .attitude_i(attitude), .bank_i(bank), .pole_case_i(pole_case),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Receiver side: random stalls by phase, or one long counted hold-off on request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        for (int n = 0; n < 400; n++) @(posedge clk);
        hold_done <= 1'b1;
      end
      out_stall <= (phase == 2) ? chance(71) : (phase == 3) ? chance(11) : 1'b0;
    end
  end

  task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w);
    while ((phase == 1 && chance(71)) || (phase == 3 && chance(11))) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    qx <= x;
    qy <= y;
    qz <= z;
    qw <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [13:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random;
    int k;
    logic [15:0] c [4];
    k = $urandom_range(2);
    for (int j = 0; j < 4; j++) begin
      if (k == 0) c[j] = 16'($urandom);
      else if (k == 1) c[j] = 16'($signed($urandom_range(32768)) - 16384);
      else c[j] = 16'(($urandom_range(1) ? 8192 : -8192) + $signed($urandom_range(64)) - 32);
    end
    send_quat(c[0], c[1], c[2], c[3]);
  endtask

  logic        deg_set [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  logic [13:0] thr_set [6] = '{14'd8176, 14'd8176, 14'd0, 14'd8192, 14'd16383, 14'd4096};

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: zero vector, extremes, identity, both poles and a non-unit input.
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd16384);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
    send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    send_quat(16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192);
    send_quat(-16'sd8192, 16'sd8192, 16'sd8192, -16'sd8192);
    send_quat(16'sd8180, 16'sd8180, 16'sd8180, 16'sd8180);
    send_quat(16'sd1, -16'sd1, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd30000, 16'sd0);
    drain();
    for (int s = 0; s < 6; s++) begin
      write_reg(CFG_DEGREE_MODE, {13'd0, deg_set[s]});
      write_reg(CFG_POLE_THRESHOLD, thr_set[s]);
      for (int p = 0; p < 4; p++) begin
        phase = p;
        // Fill the pipeline against a long receiver hold-off once.
        if (s == 0 && p == 0) hold_req <= 1'b1;
        for (int n = 0; n < 52; n++) send_random();
      end
      phase = 0;
      drain();
    end
    if (fail_count == 0 && pending == 0) begin
      $display("[quaternion_to_euler_unit] OK");
    end else begin
      $display("[quaternion_to_euler_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[quaternion_to_euler_unit] ERROR");
    $finish;
  end

endmodule

[files.f]
design/q2e_pkg.sv
design/q2e_cordic.sv
design/quaternion_to_euler_unit.sv
dv/q2e_scoreboard.sv
dv/quaternion_to_euler_unit_tb.sv
